// File: src/fpalu_pkg.sv
package fpalu_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 8;
    localparam int DIVD_W    = DATA_W + FRAC_W;
    localparam int DIV_STEPS = DIVD_W;
    localparam int LATENCY   = DIV_STEPS + 3;
    localparam int PROD_W    = 2 * DATA_W;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_EQ       = 4'd4,
        OP_NE       = 4'd5,
        OP_GT       = 4'd6,
        OP_LT       = 4'd7,
        OP_GE       = 4'd8,
        OP_LE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               neg;
        logic [DATA_W-1:0]  res;
        logic               cmp;
        logic [1:0]         status;
        logic [DATA_W-1:0]  rem;
        logic [DIVD_W-1:0]  nq;
        logic [DATA_W-1:0]  dvs;
    } stage_t;

    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MAX_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic [DATA_W-1:0] sat_limit(input logic neg);
        sat_limit = neg ? MAX_NEG : MAX_POS;
    endfunction

endpackage

// File: src/fixed_point_alu.sv
// Q24.8 signed fixed-point ALU. Issue an item by raising start for one cycle with
// req_type, operand_a and operand_b; busy stays low, so an item may be issued in
// every cycle. Each item yields exactly one result, shown for one cycle with done
// high. Every operation passes through the same pipeline, whose length is set by
// the 40-stage restoring divider, one quotient bit a stage, which all operations
// travel alongside to keep results in order.
// The receiver cannot stall; results must be taken when done is high.
module fixed_point_alu (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [3:0]                          req_type,
    input  logic signed [fpalu_pkg::DATA_W-1:0] operand_a,
    input  logic signed [fpalu_pkg::DATA_W-1:0] operand_b,
    output logic                                done,
    output logic signed [fpalu_pkg::DATA_W-1:0] result,
    output logic                                compare_true,
    output logic [1:0]                          status
);

    localparam int DW = fpalu_pkg::DATA_W;
    localparam int FW = fpalu_pkg::FRAC_W;
    localparam int NW = fpalu_pkg::DIVD_W;
    localparam int PW = fpalu_pkg::PROD_W;
    localparam int NS = fpalu_pkg::DIV_STEPS;

    logic                 in_vld_reg;
    fpalu_pkg::op_t       in_op_reg;
    logic signed [DW-1:0] in_a_reg;
    logic signed [DW-1:0] in_b_reg;

    logic                 vld_reg [0:NS];
    fpalu_pkg::stage_t    st_reg  [0:NS];
    fpalu_pkg::stage_t    st_next [0:NS];
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        prod_next;

    logic                 done_reg;
    logic [DW-1:0]        res_reg;
    logic [DW-1:0]        res_next;
    logic                 cmp_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        in_op_reg <= fpalu_pkg::op_t'(req_type);
        in_a_reg  <= operand_a;
        in_b_reg  <= operand_b;
    end

    // operand preparation and the combinational operations
    always_comb
    begin
        logic          na;
        logic          nb;
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic [DW:0]   sum;
        logic          do_sum;
        fpalu_pkg::stage_t s;

        na = in_a_reg[DW-1];
        nb = in_b_reg[DW-1];
        ma = na ? DW'(-in_a_reg) : DW'(in_a_reg);
        mb = nb ? DW'(-in_b_reg) : DW'(in_b_reg);
        sum = '0;
        do_sum = 1'b0;

        s.op     = in_op_reg;
        s.neg    = na ^ nb;
        s.res    = '0;
        s.cmp    = 1'b0;
        s.status = fpalu_pkg::ST_OK;
        s.rem    = '0;
        s.nq     = {ma, {FW{1'b0}}};
        s.dvs    = mb;

        unique case (in_op_reg)
            fpalu_pkg::OP_ADD:
            begin
                sum = {in_a_reg[DW-1], in_a_reg} + {in_b_reg[DW-1], in_b_reg};
                do_sum = 1'b1;
            end
            fpalu_pkg::OP_SUB:
            begin
                sum = {in_a_reg[DW-1], in_a_reg} - {in_b_reg[DW-1], in_b_reg};
                do_sum = 1'b1;
            end
            fpalu_pkg::OP_INC:
            begin
                sum = {in_a_reg[DW-1], in_a_reg} + (DW+1)'(1);
                do_sum = 1'b1;
            end
            fpalu_pkg::OP_DEC:
            begin
                sum = {in_a_reg[DW-1], in_a_reg} - (DW+1)'(1);
                do_sum = 1'b1;
            end
            fpalu_pkg::OP_MUL:
            begin
            end
            fpalu_pkg::OP_DIV:
            begin
                if (mb == '0)
                begin
                    s.status = fpalu_pkg::ST_DZ;
                end
            end
            fpalu_pkg::OP_EQ: s.cmp = (in_a_reg == in_b_reg);
            fpalu_pkg::OP_NE: s.cmp = (in_a_reg != in_b_reg);
            fpalu_pkg::OP_GT: s.cmp = (in_a_reg > in_b_reg);
            fpalu_pkg::OP_LT: s.cmp = (in_a_reg < in_b_reg);
            fpalu_pkg::OP_GE: s.cmp = (in_a_reg >= in_b_reg);
            fpalu_pkg::OP_LE: s.cmp = (in_a_reg <= in_b_reg);
            fpalu_pkg::OP_MIN: s.res = (in_a_reg < in_b_reg) ? in_a_reg : in_b_reg;
            fpalu_pkg::OP_MAX: s.res = (in_a_reg > in_b_reg) ? in_a_reg : in_b_reg;
            fpalu_pkg::OP_FROM_INT:
            begin
                if ((&in_a_reg[DW-1:DW-1-FW]) || !(|in_a_reg[DW-1:DW-1-FW]))
                begin
                    s.res = {in_a_reg[DW-1-FW:0], {FW{1'b0}}};
                end
                else
                begin
                    s.res    = fpalu_pkg::sat_limit(na);
                    s.status = fpalu_pkg::ST_OVF;
                end
            end
            fpalu_pkg::OP_TO_INT: s.res = DW'(in_a_reg >>> FW);
            default:
            begin
            end
        endcase

        if (do_sum)
        begin
            if (sum[DW] != sum[DW-1])
            begin
                s.res    = fpalu_pkg::sat_limit(sum[DW]);
                s.status = fpalu_pkg::ST_OVF;
            end
            else
            begin
                s.res = sum[DW-1:0];
            end
        end

        st_next[0] = s;
        prod_next  = PW'(ma) * PW'(mb);
    end

    // divider steps; the first step also rounds and packs the product
    for (genvar g = 1; g <= NS; g++)
    begin : g_step
        always_comb
        begin
            logic [DW:0]   sh;
            logic [PW-1:0] m;
            fpalu_pkg::stage_t s;

            s  = st_reg[g-1];
            sh = {s.rem, s.nq[NW-1]};
            if (sh >= {1'b0, s.dvs})
            begin
                s.rem = DW'(sh - {1'b0, s.dvs});
                s.nq  = {s.nq[NW-2:0], 1'b1};
            end
            else
            begin
                s.rem = sh[DW-1:0];
                s.nq  = {s.nq[NW-2:0], 1'b0};
            end
            m = '0;
            if (g == 1 && s.op == fpalu_pkg::OP_MUL)
            begin
                m = (prod_reg + (PW'(1) << (FW-1))) >> FW;
                if (m > PW'(fpalu_pkg::sat_limit(s.neg)))
                begin
                    s.res    = fpalu_pkg::sat_limit(s.neg);
                    s.status = fpalu_pkg::ST_OVF;
                end
                else
                begin
                    s.res = s.neg ? DW'(-m[DW-1:0]) : m[DW-1:0];
                end
            end
            st_next[g] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_vld_reg;
            for (int i = 1; i <= NS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        for (int i = 0; i <= NS; i++)
        begin
            st_reg[i] <= st_next[i];
        end
    end

    // quotient rounding and packing
    always_comb
    begin
        logic          rnd;
        logic [NW:0]   q;
        fpalu_pkg::stage_t s;

        s           = st_reg[NS];
        rnd         = ({s.rem, 1'b0} >= {1'b0, s.dvs});
        q           = {1'b0, s.nq} + (NW+1)'(rnd);
        res_next    = s.res;
        status_next = s.status;
        if (s.op == fpalu_pkg::OP_DIV && s.status != fpalu_pkg::ST_DZ)
        begin
            if (q > (NW+1)'(fpalu_pkg::sat_limit(s.neg)))
            begin
                res_next    = fpalu_pkg::sat_limit(s.neg);
                status_next = fpalu_pkg::ST_OVF;
            end
            else
            begin
                res_next = s.neg ? DW'(-q[DW-1:0]) : q[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        cmp_reg    <= st_reg[NS].cmp;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign result       = res_reg;
    assign compare_true = cmp_reg;
    assign status       = status_reg;

endmodule

// File: src/fixed_point_alu_check.sv
module fixed_point_alu_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [fpalu_pkg::DATA_W-1:0] result,
    input logic                        compare_true,
    input logic [1:0]                  status
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(fpalu_pkg::LATENCY) done)
        else $error("item result missing at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, fpalu_pkg::LATENCY))
        else $error("result without an issued item");

    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && compare_true |-> result == '0 && status == fpalu_pkg::ST_OK)
        else $error("comparison result carries data or status");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == fpalu_pkg::ST_DZ |-> result == '0 && !compare_true)
        else $error("division by zero gives nonzero result");

endmodule

bind fixed_point_alu fixed_point_alu_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result       (result),
    .compare_true (compare_true),
    .status       (status)
);
